### hdl/ems_pkg.sv
// Shared types, widths and helpers for the ellipse midpoint stepper.
package ems_pkg;

  localparam int RADIUS_BITS = 11;
  localparam int COORD_BITS  = 16;

  localparam int PT_W   = 16;
  localparam int RIN_W  = 11;
  localparam int SQ_W   = 2 * RADIUS_BITS;
  localparam int OFF_W  = RADIUS_BITS + 1;
  localparam int FAC_W  = RADIUS_BITS + 4;
  localparam int PROD_W = SQ_W + FAC_W;
  localparam int DEC_W  = PROD_W + 3;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic signed [PT_W-1:0]  center_x;
    logic signed [PT_W-1:0]  center_y;
    logic [RIN_W-1:0]        radius_x;
    logic [RIN_W-1:0]        radius_y;
  } in_item_t;

  typedef struct packed {
    logic signed [PT_W-1:0] pt0_x;
    logic signed [PT_W-1:0] pt0_y;
    logic signed [PT_W-1:0] pt1_x;
    logic signed [PT_W-1:0] pt1_y;
    logic signed [PT_W-1:0] pt2_x;
    logic signed [PT_W-1:0] pt2_y;
    logic signed [PT_W-1:0] pt3_x;
    logic signed [PT_W-1:0] pt3_y;
    logic                   region;
    logic                   last_point;
    logic                   point_valid;
  } out_item_t;

  typedef struct packed {
    logic [SQ_W-1:0]         a;
    logic signed [FAC_W-1:0] b;
  } mul_req_t;

  // Center plus or minus offset, wrapped to the coordinate width, sign-extended.
  function automatic logic signed [PT_W-1:0] wrap_coord(
    input logic [COORD_BITS-1:0] c,
    input logic [OFF_W-1:0]      o,
    input logic                  add
  );
    logic [COORD_BITS-1:0]        ot;
    logic signed [COORD_BITS-1:0] v;
    ot = COORD_BITS'(o);
    v  = add ? (c + ot) : (c - ot);
    return PT_W'(v);
  endfunction

endpackage

### hdl/ems_mul.sv
// Shared registered multiplier: unsigned square-width operand times signed factor.
module ems_mul (
  input  logic                               clk,
  input  ems_pkg::mul_req_t                  req,
  output logic signed [ems_pkg::PROD_W-1:0]  prod
);

  logic signed [ems_pkg::SQ_W:0]       a_s;
  logic signed [ems_pkg::PROD_W-1:0]   prod_nxt;
  logic signed [ems_pkg::PROD_W-1:0]   prod_r;

  assign a_s      = $signed({1'b0, req.a});
  assign prod_nxt = a_s * req.b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

### hdl/ems_engine.sv
// Sequencer and datapath of the midpoint ellipse stepper around one multiplier.
module ems_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ems_pkg::in_item_t   item,
  output logic                ready,
  output logic                res_valid,
  input  logic                res_ready,
  output ems_pkg::out_item_t  res
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LD_SQX = 4'd1;
  localparam logic [3:0] ST_LD_SQY = 4'd2;
  localparam logic [3:0] ST_LD_DEC = 4'd3;
  localparam logic [3:0] ST_LD_FIN = 4'd4;
  localparam logic [3:0] ST_EMIT   = 4'd5;
  localparam logic [3:0] ST_S_A    = 4'd6;
  localparam logic [3:0] ST_S_B    = 4'd7;
  localparam logic [3:0] ST_S_C    = 4'd8;
  localparam logic [3:0] ST_S_D    = 4'd9;
  localparam logic [3:0] ST_S_E    = 4'd10;
  localparam logic [3:0] ST_S_F    = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  localparam int RB = ems_pkg::RADIUS_BITS;
  localparam int CB = ems_pkg::COORD_BITS;
  localparam int SW = ems_pkg::SQ_W;
  localparam int OW = ems_pkg::OFF_W;
  localparam int FW = ems_pkg::FAC_W;
  localparam int PW = ems_pkg::PROD_W;
  localparam int DW = ems_pkg::DEC_W;

  logic [3:0]                state_r, state_nxt;
  logic                      active_r, active_nxt;
  logic [CB-1:0]             cen_x_r, cen_x_nxt, cen_y_r, cen_y_nxt;
  logic [RB-1:0]             rad_x_r, rad_x_nxt, rad_y_r, rad_y_nxt;
  logic [SW-1:0]             sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [OW-1:0]             off_x_r, off_x_nxt, off_y_r, off_y_nxt;
  logic signed [DW-1:0]      dec_r, dec_nxt;
  logic                      region_r, region_nxt;
  logic                      dge_r, dge_nxt;
  logic signed [PW-1:0]      cmp_r, cmp_nxt;
  ems_pkg::out_item_t        res_r, res_nxt;

  ems_pkg::mul_req_t         mreq;
  logic signed [PW-1:0]      prod;
  logic signed [DW-1:0]      prod_ext;

  logic [RB-1:0]             in_rx, in_ry;
  logic                      bad_rad;
  logic [OW-1:0]             p_cur, q_cur;
  logic [SW-1:0]             sq_p, sq_q;

  ems_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  assign prod_ext = {{(DW-PW){prod[PW-1]}}, prod};
  assign in_rx    = RB'(item.radius_x);
  assign in_ry    = RB'(item.radius_y);
  assign bad_rad  = (in_rx < RB'(2)) || (in_ry < RB'(2));

  // p is the coordinate stepped every time, q the one stepped on a nonnegative decision
  assign p_cur = region_r ? off_y_r : off_x_r;
  assign q_cur = region_r ? off_x_r : off_y_r;
  assign sq_p  = region_r ? sqx_r : sqy_r;
  assign sq_q  = region_r ? sqy_r : sqx_r;

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    cen_x_nxt  = cen_x_r;
    cen_y_nxt  = cen_y_r;
    rad_x_nxt  = rad_x_r;
    rad_y_nxt  = rad_y_r;
    sqx_nxt    = sqx_r;
    sqy_nxt    = sqy_r;
    off_x_nxt  = off_x_r;
    off_y_nxt  = off_y_r;
    dec_nxt    = dec_r;
    region_nxt = region_r;
    dge_nxt    = dge_r;
    cmp_nxt    = cmp_r;
    res_nxt    = res_r;
    mreq.a     = sq_p;
    mreq.b     = FW'(p_cur);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (item.opcode == ems_pkg::OP_LOAD) begin
            if (bad_rad) begin
              active_nxt = 1'b0;
              res_nxt    = '0;
              state_nxt  = ST_DONE;
            end else begin
              cen_x_nxt = CB'(item.center_x);
              cen_y_nxt = CB'(item.center_y);
              rad_x_nxt = in_rx;
              rad_y_nxt = in_ry;
              state_nxt = ST_LD_SQX;
            end
          end else if (!active_r) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_LD_SQX: begin
        mreq.a    = SW'(rad_x_r);
        mreq.b    = FW'(rad_x_r);
        state_nxt = ST_LD_SQY;
      end
      ST_LD_SQY: begin
        sqx_nxt   = prod[SW-1:0];
        mreq.a    = SW'(rad_y_r);
        mreq.b    = FW'(rad_y_r);
        state_nxt = ST_LD_DEC;
      end
      ST_LD_DEC: begin
        sqy_nxt   = prod[SW-1:0];
        mreq.a    = sqx_r;
        mreq.b    = FW'(1) - (FW'(rad_y_r) << 1);
        state_nxt = ST_LD_FIN;
      end
      ST_LD_FIN: begin
        dec_nxt    = DW'({sqy_r, 1'b0}) + prod_ext;
        off_x_nxt  = '0;
        off_y_nxt  = OW'(rad_y_r);
        region_nxt = 1'b0;
        active_nxt = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        res_nxt.pt0_x       = ems_pkg::wrap_coord(cen_x_r, off_x_r, 1'b1);
        res_nxt.pt0_y       = ems_pkg::wrap_coord(cen_y_r, off_y_r, 1'b1);
        res_nxt.pt1_x       = ems_pkg::wrap_coord(cen_x_r, off_x_r, 1'b0);
        res_nxt.pt1_y       = ems_pkg::wrap_coord(cen_y_r, off_y_r, 1'b1);
        res_nxt.pt2_x       = ems_pkg::wrap_coord(cen_x_r, off_x_r, 1'b0);
        res_nxt.pt2_y       = ems_pkg::wrap_coord(cen_y_r, off_y_r, 1'b0);
        res_nxt.pt3_x       = ems_pkg::wrap_coord(cen_x_r, off_x_r, 1'b1);
        res_nxt.pt3_y       = ems_pkg::wrap_coord(cen_y_r, off_y_r, 1'b0);
        res_nxt.region      = region_r;
        res_nxt.last_point  = 1'b0;
        res_nxt.point_valid = 1'b1;
        state_nxt           = ST_S_A;
      end
      ST_S_A: begin
        dge_nxt   = !dec_r[DW-1];
        mreq.a    = sq_q;
        mreq.b    = FW'(1) - FW'(q_cur);
        state_nxt = ST_S_B;
      end
      ST_S_B: begin
        if (dge_r) begin
          dec_nxt = dec_r + (prod_ext <<< 2);
          if (region_r) begin
            off_x_nxt = off_x_r - OW'(1);
          end else begin
            off_y_nxt = off_y_r - OW'(1);
          end
        end
        mreq.a    = sq_p;
        mreq.b    = (FW'(p_cur) << 2) + FW'(6);
        state_nxt = ST_S_C;
      end
      ST_S_C: begin
        dec_nxt = dec_r + prod_ext;
        if (region_r) begin
          off_y_nxt = off_y_r + OW'(1);
        end else begin
          off_x_nxt = off_x_r + OW'(1);
        end
        mreq.a    = sq_p;
        mreq.b    = FW'(p_cur) + FW'(1);
        state_nxt = ST_S_D;
      end
      ST_S_D: begin
        cmp_nxt   = prod;
        mreq.a    = sq_q;
        mreq.b    = FW'(q_cur);
        state_nxt = ST_S_E;
      end
      ST_S_E: begin
        state_nxt = ST_DONE;
        if (cmp_r > prod) begin
          if (region_r) begin
            active_nxt = 1'b0;
          end else begin
            // switch to the second region, restart from (rx, 0)
            region_nxt = 1'b1;
            off_x_nxt  = OW'(rad_x_r);
            off_y_nxt  = '0;
            mreq.a     = sqy_r;
            mreq.b     = FW'(1) - (FW'(rad_x_r) << 1);
            state_nxt  = ST_S_F;
          end
        end
      end
      ST_S_F: begin
        dec_nxt   = DW'({sqx_r, 1'b0}) + prod_ext;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cen_x_r  <= cen_x_nxt;
    cen_y_r  <= cen_y_nxt;
    rad_x_r  <= rad_x_nxt;
    rad_y_r  <= rad_y_nxt;
    sqx_r    <= sqx_nxt;
    sqy_r    <= sqy_nxt;
    off_x_r  <= off_x_nxt;
    off_y_r  <= off_y_nxt;
    dec_r    <= dec_nxt;
    region_r <= region_nxt;
    dge_r    <= dge_nxt;
    cmp_r    <= cmp_nxt;
    res_r    <= res_nxt;
  end

  assign ready     = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  always_comb begin
    res            = res_r;
    res.last_point = !active_r;
  end

  a_bad_load_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    (ready && start && item.opcode == ems_pkg::OP_LOAD && bad_rad)
      |=> (state_r == ST_DONE && !active_r && !res_r.point_valid))
    else $error("rejected load did not go idle");

  a_steps_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_S_A || state_r == ST_S_B || state_r == ST_S_C || state_r == ST_S_D)
      |-> active_r)
    else $error("advance sequence running while generator is idle");

  a_restart_region: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_S_F) |-> (region_r && off_y_r == '0 && $past(!region_r)))
    else $error("region two restart out of order");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result changed before transfer");

endmodule

### hdl/ellipse_midpoint_stepper.sv
// Top level: input handshake, stepping engine and the result register.
//
//  channel  direction  signals                      payload
//  in       input      in_valid, in_ready, in_data  ems_pkg::in_item_t
//  out      output     out_valid, out_ready, out_data  ems_pkg::out_item_t
//
// A load makes three passes and an advance up to five through the one
// registered 22x15 multiplier, one per cycle. An advance with nothing to
// draw, or a rejected load, goes straight to an empty result.
// rst_n is synchronous; it idles the sequencer and drops any held result.
// A result waiting on out_ready does not block a new input transfer; the
// engine holds its next result until the output register frees.
module ellipse_midpoint_stepper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ems_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ems_pkg::out_item_t  out_data
);

  logic                eng_ready;
  logic                res_valid;
  logic                res_ready;
  ems_pkg::out_item_t  res;

  logic                out_valid_r, out_valid_nxt;
  ems_pkg::out_item_t  out_data_r, out_data_nxt;

  ems_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid),
    .item      (in_data),
    .ready     (eng_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign in_ready  = eng_ready;
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    // load the register whenever it is empty or draining this cycle
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
